// ===== rtl/ps2x_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2x_pkg
// Shared constants and types for the Scale2x pixel-art upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2x_pkg;

   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int PIXEL_BITS_DEF  = 16;

   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam int ROW_BITS        = 12;
   localparam int SRC_X_BITS      = 10;
   localparam int SRC_Y_BITS      = 12;
   localparam int MAX_HEIGHT      = 4096;

   localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd1024;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACTION_PIXEL = 1'b0,
      ACTION_DRAIN = 1'b1
   } action_type;

   // Rounds a bit count up to whole bytes.
   function automatic int byte_round(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ps2x_line_store.sv =====
// ----------------------------------------------------------------------------
// ps2x_line_store
// One row of source pixels: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2x_line_store #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr_0,
   input  logic [ADDR_BITS-1:0] rd_addr_1,
   output logic [DATA_BITS-1:0] rd_data_0,
   output logic [DATA_BITS-1:0] rd_data_1
);

   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_0_ff;
   logic [DATA_BITS-1:0] rd_data_1_ff;

   // A read at the address being written returns the value before the write.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_0_ff <= store_ff[rd_addr_0];
         rd_data_1_ff <= store_ff[rd_addr_1];
      end
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data_0 = rd_data_0_ff;
   assign rd_data_1 = rd_data_1_ff;

endmodule

`default_nettype wire

// ===== rtl/pixel_art_scale2x.sv =====
// ----------------------------------------------------------------------------
// pixel_art_scale2x
// Scale2x upscaler: raster-order source pixels in, one 2x2 block per pixel out.
// ----------------------------------------------------------------------------
//   Port group  Direction  Carries
//   req_*       in         source pixel or drain step (tuser = action)
//   rsp_*       out        2x2 block with its source column and row (tlast = last)
//   csr_*       in/out     image_width at 0x0, image_height at 0x4
//
// One item is accepted per clock while req_tready is high. The accepting edge
// registers the line store reads in the input stage; the block rule's output is
// then registered into the output register as soon as that register can move.
// The two line stores are read at two addresses each per item.
// Reset clears counters and valid flags; the line stores keep their contents.
// A stall on rsp only holds req_tready low once the input stage is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_art_scale2x #(
   parameter int MAX_WIDTH  = ps2x_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = ps2x_pkg::PIXEL_BITS_DEF,
   localparam int REQ_TDATA_W = ps2x_pkg::byte_round(PIXEL_BITS),
   localparam int RSP_TDATA_W = ps2x_pkg::byte_round(4 * PIXEL_BITS
                                + ps2x_pkg::SRC_X_BITS + ps2x_pkg::SRC_Y_BITS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [REQ_TDATA_W-1:0]               req_tdata,   // pixel_value
   input  logic                                 req_tuser,   // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // top_left, top_right, bottom_left, bottom_right, source_x, source_y
   output logic [RSP_TDATA_W-1:0]               rsp_tdata,
   output logic                                 rsp_tlast,   // last_block
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ps2x_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [ps2x_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [ps2x_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   import ps2x_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WCMP_BITS = (COL_BITS + 1 > CFG_WIDTH_BITS) ? COL_BITS + 1 : CFG_WIDTH_BITS;
   localparam int RSP_BITS  = 4 * PIXEL_BITS + SRC_X_BITS + SRC_Y_BITS;

   // ---------------- configuration registers ----------------
   logic [CFG_WIDTH_BITS-1:0]  image_width_ff, image_width_in;
   logic [CFG_HEIGHT_BITS-1:0] image_height_ff, image_height_in;
   logic                       csr_write;
   csr_index_type              csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_pwdata[CFG_WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_pwdata[CFG_HEIGHT_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(image_width_ff);
         CSR_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(image_height_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // Out-of-range settings are clamped to the usable range.
   logic [WCMP_BITS-1:0]       width_wide;
   logic [WCMP_BITS-1:0]       eff_width;
   logic [CFG_HEIGHT_BITS-1:0] eff_height;

   assign width_wide = WCMP_BITS'(image_width_ff);

   always_comb begin
      if (width_wide == '0) begin
         eff_width = WCMP_BITS'(1);
      end else if (width_wide > WCMP_BITS'(MAX_WIDTH)) begin
         eff_width = WCMP_BITS'(MAX_WIDTH);
      end else begin
         eff_width = width_wide;
      end
      if (image_height_ff == '0) begin
         eff_height = CFG_HEIGHT_BITS'(1);
      end else if (image_height_ff > CFG_HEIGHT_BITS'(MAX_HEIGHT)) begin
         eff_height = CFG_HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         eff_height = image_height_ff;
      end
   end

   // ---------------- position state ----------------
   logic [COL_BITS-1:0] column_ff, column_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                line_select_ff, line_select_in;
   logic [COL_BITS-1:0] drain_column_ff, drain_column_in;
   logic                image_complete_ff, image_complete_in;

   logic                  req_fire;
   action_type            action;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  pixel_take;
   logic                  drain_take;
   logic                  column_last;
   logic                  row_last;
   logic                  drain_last;
   logic [COL_BITS-1:0]   cur_x;
   logic [COL_BITS-1:0]   next_x;
   logic                  s1_move;

   logic                  s1_valid_ff, s1_valid_in;
   logic [COL_BITS-1:0]   s1_x_ff;
   logic [ROW_BITS-1:0]   s1_y_ff;
   logic                  s1_last_ff;
   logic                  s1_have_b_ff;
   logic                  s1_have_d_ff;
   logic                  s1_have_f_ff;
   logic                  s1_have_h_ff;
   logic [PIXEL_BITS-1:0] s1_h_ff;
   logic                  s1_sel_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]   rsp_data_ff;
   logic                  rsp_last_ff;

   assign s1_move    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | s1_move;
   assign req_fire   = req_tvalid & req_tready;
   assign action     = action_type'(req_tuser);
   assign pixel      = req_tdata[PIXEL_BITS-1:0];

   // Pixels during the drain and drain steps before it are accepted and dropped.
   assign pixel_take = req_fire & (action == ACTION_PIXEL) & ~image_complete_ff;
   assign drain_take = req_fire & (action == ACTION_DRAIN) & image_complete_ff;

   assign column_last = (WCMP_BITS'(column_ff) + WCMP_BITS'(1)) >= eff_width;
   assign drain_last  = (WCMP_BITS'(drain_column_ff) + WCMP_BITS'(1)) >= eff_width;
   assign row_last    = (CFG_HEIGHT_BITS'(row_ff) + CFG_HEIGHT_BITS'(1)) >= eff_height;

   assign cur_x  = (action == ACTION_DRAIN) ? drain_column_ff : column_ff;
   assign next_x = cur_x + COL_BITS'(1);

   always_comb begin
      column_in         = column_ff;
      row_in            = row_ff;
      line_select_in    = line_select_ff;
      drain_column_in   = drain_column_ff;
      image_complete_in = image_complete_ff;
      if (pixel_take) begin
         if (column_last) begin
            column_in      = '0;
            line_select_in = ~line_select_ff;
            if (row_last) begin
               image_complete_in = 1'b1;
            end else begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end else begin
            column_in = column_ff + COL_BITS'(1);
         end
      end else if (drain_take) begin
         if (drain_last) begin
            drain_column_in   = '0;
            column_in         = '0;
            row_in            = '0;
            image_complete_in = 1'b0;
         end else begin
            drain_column_in = drain_column_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff         <= '0;
         row_ff            <= '0;
         line_select_ff    <= 1'b0;
         drain_column_ff   <= '0;
         image_complete_ff <= 1'b0;
      end else begin
         column_ff         <= column_in;
         row_ff            <= row_in;
         line_select_ff    <= line_select_in;
         drain_column_ff   <= drain_column_in;
         image_complete_ff <= image_complete_in;
      end
   end

   // ---------------- line stores ----------------
   // With line_select low, store A holds the most recent row and B the one
   // before it; the arriving pixel overwrites the older row.
   logic [PIXEL_BITS-1:0] a_rd_0, a_rd_1, b_rd_0, b_rd_1;

   ps2x_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (PIXEL_BITS)
   ) u_line_a (
      .clock     (clock),
      .wr_en     (pixel_take & line_select_ff),
      .wr_addr   (column_ff),
      .wr_data   (pixel),
      .rd_en     (req_fire),
      .rd_addr_0 (cur_x),
      .rd_addr_1 (next_x),
      .rd_data_0 (a_rd_0),
      .rd_data_1 (a_rd_1)
   );

   ps2x_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (PIXEL_BITS)
   ) u_line_b (
      .clock     (clock),
      .wr_en     (pixel_take & ~line_select_ff),
      .wr_addr   (column_ff),
      .wr_data   (pixel),
      .rd_en     (req_fire),
      .rd_addr_0 (cur_x),
      .rd_addr_1 (next_x),
      .rd_data_0 (b_rd_0),
      .rd_data_1 (b_rd_1)
   );

   // ---------------- input stage ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = (pixel_take & (row_ff != '0)) | drain_take;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // A pixel finishes the block of the row above it; a drain step finishes
   // a block of the last row, which has no row below.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff      <= cur_x;
         s1_sel_ff    <= line_select_ff;
         s1_have_d_ff <= (cur_x != '0);
         s1_have_f_ff <= (WCMP_BITS'(cur_x) + WCMP_BITS'(1)) < eff_width;
         s1_h_ff      <= pixel;
         if (action == ACTION_DRAIN) begin
            s1_y_ff      <= row_ff;
            s1_last_ff   <= drain_last;
            s1_have_b_ff <= (row_ff != '0);
            s1_have_h_ff <= 1'b0;
         end else begin
            s1_y_ff      <= row_ff - ROW_BITS'(1);
            s1_last_ff   <= 1'b0;
            s1_have_b_ff <= (row_ff > ROW_BITS'(1));
            s1_have_h_ff <= 1'b1;
         end
      end
   end

   // ---------------- block rule ----------------
   logic [PIXEL_BITS-1:0] recent_0, recent_1, earlier_0;
   logic [PIXEL_BITS-1:0] nb_b, nb_d, nb_e, nb_f, nb_h;
   logic [PIXEL_BITS-1:0] out_tl, out_tr, out_bl, out_br;
   logic [PIXEL_BITS-1:0] prev_e_ff;

   assign recent_0  = s1_sel_ff ? b_rd_0 : a_rd_0;
   assign recent_1  = s1_sel_ff ? b_rd_1 : a_rd_1;
   assign earlier_0 = s1_sel_ff ? a_rd_0 : b_rd_0;

   // The left neighbour is the centre of the block handled just before,
   // which is always the previous column of the same row.
   assign nb_e = recent_0;
   assign nb_d = s1_have_d_ff ? prev_e_ff : nb_e;
   assign nb_f = s1_have_f_ff ? recent_1 : nb_e;
   assign nb_b = s1_have_b_ff ? earlier_0 : nb_e;
   assign nb_h = s1_have_h_ff ? s1_h_ff : nb_e;

   always_comb begin
      out_tl = nb_e;
      out_tr = nb_e;
      out_bl = nb_e;
      out_br = nb_e;
      if ((nb_b != nb_h) && (nb_d != nb_f)) begin
         out_tl = (nb_d == nb_b) ? nb_d : nb_e;
         out_tr = (nb_b == nb_f) ? nb_f : nb_e;
         out_bl = (nb_d == nb_h) ? nb_d : nb_e;
         out_br = (nb_h == nb_f) ? nb_f : nb_e;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff & s1_move) begin
         prev_e_ff   <= nb_e;
         rsp_data_ff <= {SRC_Y_BITS'(s1_y_ff), SRC_X_BITS'(s1_x_ff),
                         out_br, out_bl, out_tr, out_tl};
         rsp_last_ff <= s1_last_ff;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_valid_ff & s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/ps2x_checker.sv =====
// ----------------------------------------------------------------------------
// ps2x_checker
// Port-level checks for the Scale2x upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2x_checker #(
   parameter int RSP_TDATA_W = ps2x_pkg::byte_round(4 * ps2x_pkg::PIXEL_BITS_DEF
                               + ps2x_pkg::SRC_X_BITS + ps2x_pkg::SRC_Y_BITS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tready,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   rsp_tlast,
   input  wire logic                   csr_pready
);

   import ps2x_pkg::*;

   // The configuration port never inserts wait states.
   a_pready_high: assert property (@(posedge clock) csr_pready)
      else $error("csr_pready went low");

   // Reset empties the output register.
   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // With no result waiting, the input side must be open.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low while output register is empty");

   // A stalled result stays put until it is taken.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed or dropped");

endmodule

bind pixel_art_scale2x ps2x_checker #(
   .RSP_TDATA_W (RSP_TDATA_W)
) u_ps2x_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Scale2x pixel-art upscaler. Source pixels and
// drain steps stream in on req_*, 2x2 blocks are checked on rsp_* against a
// line-store predictor updated on every accepted transfer. Image sizes are
// programmed over csr_* between images, with one height change mid-image.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import ps2x_pkg::*;

   localparam int MAX_W = 1024;
   // Four 16-bit pixels, a 10-bit column and a 12-bit row, rounded up to bytes.
   localparam int RSP_W = 88;

   typedef struct {
      logic [15:0] top_left;
      logic [15:0] top_right;
      logic [15:0] bottom_left;
      logic [15:0] bottom_right;
      logic [9:0]  source_x;
      logic [11:0] source_y;
      logic        last_block;
   } scaled_block_type;

   typedef struct {
      action_type  act;
      logic [15:0] pixel;
   } source_item_type;

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_tvalid   = 1'b0;
   logic             req_tready;
   logic [15:0]      req_tdata    = '0;   // pixel_value
   logic             req_tuser    = 1'b0; // action
   logic             rsp_tvalid;
   logic             rsp_tready   = 1'b0;
   // top_left, top_right, bottom_left, bottom_right, source_x, source_y
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;           // last_block
   logic             csr_psel     = 1'b0;
   logic             csr_penable  = 1'b0;
   logic             csr_pwrite   = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr  = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic             csr_pready;

   pixel_art_scale2x u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   source_item_type  source_items [$];
   scaled_block_type pending_blocks [$];
   source_item_type  held_item;
   scaled_block_type want_block;
   bit            steady = 1'b0;
   int            error_count = 0;
   int            blocks_checked = 0;
   int            ignored_items = 0;
   int            frames_done = 0;
   int            fed_items = 0;

   // Shadow of the block: register copies, counters and both line stores.
   logic [10:0] width_reg  = WIDTH_RESET;
   logic [12:0] height_reg = HEIGHT_RESET;
   logic [15:0] line_mem [2][MAX_W];
   bit          bank_sel   = 1'b0;
   bit          frame_done = 1'b0;
   int          col_pos    = 0;
   int          row_pos    = 0;
   int          drain_pos  = 0;

   function automatic int active_width(input logic [10:0] value);
      if (value == 0) return 1;
      if (value > MAX_W) return MAX_W;
      return int'(value);
   endfunction

   function automatic int active_height(input logic [12:0] value);
      if (value == 0) return 1;
      if (value > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(value);
   endfunction

   // Builds the 2x2 block for column x of the most recent complete row.
   function automatic scaled_block_type expand_block(input int x, input int w,
         input logic [15:0] above, input bit have_above, input logic [15:0] below,
         input bit have_below, input int y, input bit is_last);
      scaled_block_type blk;
      logic [15:0] b, d, e, f, h;
      e = line_mem[bank_sel][x];
      d = (x > 0) ? line_mem[bank_sel][x-1] : e;
      f = (x + 1 < w) ? line_mem[bank_sel][x+1] : e;
      b = have_above ? above : e;
      h = have_below ? below : e;
      blk.top_left     = e;
      blk.top_right    = e;
      blk.bottom_left  = e;
      blk.bottom_right = e;
      if (b != h && d != f) begin
         blk.top_left     = (d == b) ? d : e;
         blk.top_right    = (b == f) ? f : e;
         blk.bottom_left  = (d == h) ? d : e;
         blk.bottom_right = (h == f) ? f : e;
      end
      blk.source_x   = x[9:0];
      blk.source_y   = y[11:0];
      blk.last_block = is_last;
      return blk;
   endfunction

   task automatic scale2x_predict(input source_item_type item);
      int w, hgt, x;
      bit is_last;
      w   = active_width(width_reg);
      hgt = active_height(height_reg);
      if (item.act == ACTION_PIXEL) begin
         if (frame_done) begin
            ignored_items++;
            return;
         end
         x = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
         // The arriving pixel is the lower neighbour of the row above it.
         if (row_pos > 0)
            pending_blocks.push_back(expand_block(x, w, line_mem[!bank_sel][x],
               row_pos > 1, item.pixel, 1'b1, row_pos - 1, 1'b0));
         line_mem[!bank_sel][x] = item.pixel;
         if (col_pos + 1 >= w) begin
            col_pos  = 0;
            bank_sel = !bank_sel;
            if (row_pos + 1 >= hgt) frame_done = 1'b1;
            else row_pos++;
         end else begin
            col_pos++;
         end
      end else begin
         if (!frame_done) begin
            ignored_items++;
            return;
         end
         x = (drain_pos >= MAX_W) ? MAX_W - 1 : drain_pos;
         is_last = (drain_pos + 1 >= w);
         pending_blocks.push_back(expand_block(x, w, line_mem[!bank_sel][x],
            row_pos > 0, 16'h0000, 1'b0, row_pos, is_last));
         if (is_last) begin
            drain_pos  = 0;
            col_pos    = 0;
            row_pos    = 0;
            frame_done = 1'b0;
            frames_done++;
         end else begin
            drain_pos++;
         end
      end
   endtask

   // Source side: a new item is offered when the previous transfer is done.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) scale2x_predict(held_item);
         if (!req_tvalid || req_tready) begin
            if (source_items.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
               held_item = source_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= held_item.pixel;
               req_tuser  <= held_item.act;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endfunction

   // Result side: every accepted block is matched against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_blocks.size() == 0) begin
               $error("unexpected block for x=%0d y=%0d", rsp_tdata[73:64], rsp_tdata[85:74]);
               error_count++;
            end else begin
               want_block = pending_blocks.pop_front();
               check_field("top_left", want_block.top_left, rsp_tdata[15:0]);
               check_field("top_right", want_block.top_right, rsp_tdata[31:16]);
               check_field("bottom_left", want_block.bottom_left, rsp_tdata[47:32]);
               check_field("bottom_right", want_block.bottom_right, rsp_tdata[63:48]);
               check_field("source_x", want_block.source_x, rsp_tdata[73:64]);
               check_field("source_y", want_block.source_y, rsp_tdata[85:74]);
               check_field("last_block", want_block.last_block, rsp_tlast);
               blocks_checked++;
            end
         end
         rsp_tready <= steady || $urandom_range(99) >= 26;
      end
   end

   task automatic push_item(input action_type act, input logic [15:0] px);
      source_items.push_back('{act: act, pixel: px});
      fed_items++;
   endtask

   // Items that produce nothing may still be in flight, hence the short pause.
   task automatic wait_idle();
      while (source_items.size() != 0 || req_tvalid || pending_blocks.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes one register, then reads it back.
   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] want, got;
      want = (idx == CSR_IMAGE_WIDTH) ? (value & 32'h7FF) : (value & 32'h1FFF);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_IMAGE_WIDTH) width_reg = value[10:0];
      else height_reg = value[12:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $error("%s readback: expected %h, got %h", idx.name(), want, got);
         error_count++;
      end
   endtask

   // One whole image: pixels in raster order, then the drain of the last row.
   // Ignored items are mixed in at the given rate.
   task automatic frame(input logic [10:0] wreg, input logic [12:0] hreg,
         input int noise_pct);
      int w, hgt;
      bit use_palette;
      logic [15:0] palette [3];
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 32'(wreg));
      csr_write(CSR_IMAGE_HEIGHT, 32'(hreg));
      w   = active_width(wreg);
      hgt = active_height(hreg);
      // A small palette makes neighbours equal often enough to exercise the rule.
      foreach (palette[i]) palette[i] = 16'($urandom);
      use_palette = ($urandom_range(99) < 70);
      for (int p = 0; p < w * hgt; p++) begin
         if ($urandom_range(99) < noise_pct) push_item(ACTION_DRAIN, 16'($urandom));
         push_item(ACTION_PIXEL, use_palette ? palette[$urandom_range(2)] : 16'($urandom));
      end
      for (int c = 0; c < w; c++) begin
         if ($urandom_range(99) < noise_pct) push_item(ACTION_PIXEL, 16'($urandom));
         push_item(ACTION_DRAIN, 16'($urandom));
      end
   endtask

   initial begin
      logic [15:0] demo [9];
      int r, wsel, hsel;
      demo = '{16'h0000, 16'h0002, 16'hFFFF,
               16'h0002, 16'h0005, 16'h0003,
               16'h0004, 16'h0003, 16'hFFFF};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Zero registers act as a single-pixel image; the first drain is too early.
      csr_write(CSR_IMAGE_WIDTH, 32'd0);
      csr_write(CSR_IMAGE_HEIGHT, 32'd0);
      push_item(ACTION_DRAIN, 16'hFFFF);
      push_item(ACTION_PIXEL, 16'hFFFF);
      push_item(ACTION_DRAIN, 16'h0000);
      wait_idle();

      // 3x3 image with all edges and the corner rule, plus a pixel during drain.
      csr_write(CSR_IMAGE_WIDTH, 32'd3);
      csr_write(CSR_IMAGE_HEIGHT, 32'd3);
      foreach (demo[i]) push_item(ACTION_PIXEL, demo[i]);
      push_item(ACTION_DRAIN, 16'h0000);
      push_item(ACTION_PIXEL, 16'h1234);
      push_item(ACTION_DRAIN, 16'h0000);
      push_item(ACTION_DRAIN, 16'h0000);
      push_item(ACTION_DRAIN, 16'h0000);
      wait_idle();

      // Height lowered mid-image: the image ends after the row in progress.
      csr_write(CSR_IMAGE_WIDTH, 32'd4);
      csr_write(CSR_IMAGE_HEIGHT, 32'd6);
      repeat (12) push_item(ACTION_PIXEL, 16'($urandom));
      wait_idle();
      csr_write(CSR_IMAGE_HEIGHT, 32'd2);
      repeat (4) push_item(ACTION_PIXEL, 16'($urandom));
      repeat (4) push_item(ACTION_DRAIN, 16'h0000);

      while (fed_items < 620) begin
         r    = $urandom_range(99);
         wsel = (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 48);
         hsel = $urandom_range(1, 8);
         frame(11'(wsel), 13'(hsel), 4);
      end

      // Wide image with no idling on either side.
      wait_idle();
      steady = 1'b1;
      frame(11'd160, 13'd2, 0);
      wait_idle();
      steady = 1'b0;

      $display("Covered %0d images and %0d checked blocks; %0d items were ignored",
               frames_done, blocks_checked, ignored_items);
      $display("Sizes ran from a single pixel to 160 columns, with zero registers as one.");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d items and %0d blocks outstanding",
               source_items.size(), pending_blocks.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
